// ----- rtl/core/fic_pkg.sv -----
// ----------------------------------------------------------------------------
// fic_pkg
// Shared widths, constants, state and command types of the Fenwick tree
// inversion counter.
// ----------------------------------------------------------------------------
package fic_pkg;

  localparam int VALUE_RANGE = 256;
  localparam int VALUE_BITS  = $clog2(VALUE_RANGE);
  localparam int NODE_BITS   = VALUE_BITS + 1;
  localparam int COUNT_BITS  = 16;
  localparam int TOTAL_BITS  = 30;
  // a prefix walk touches at most VALUE_BITS nodes of COUNT_BITS each
  localparam int ACC_BITS    = COUNT_BITS + $clog2(VALUE_BITS + 1);
  localparam int SUM_BITS    = TOTAL_BITS + 1;

  localparam logic [TOTAL_BITS-1:0] MODULUS       = TOTAL_BITS'(1000000007);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
  localparam logic [VALUE_BITS-1:0] MAX_VALUE_RST = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QHI,
    ST_QLO,
    ST_UPD,
    ST_TAIL,
    ST_DONE
  } fic_state_t;

  // what to do with a tree word once it comes back from the memory
  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_INC
  } fic_mode_t;

  typedef struct packed {
    logic      load;
    logic      seed_val;
    logic      rd_issue;
    logic      walk_up;
    fic_mode_t mode;
    logic      commit;
  } fic_cmd_t;

  typedef struct packed {
    logic node_zero;
    logic node_oob;
    logic err;
    logic val_zero;
    logic rd_pend;
  } fic_sts_t;

endpackage

// ----- rtl/core/fic_dp.sv -----
// ----------------------------------------------------------------------------
// fic_dp
// Datapath: tree memory with valid bits, node walker, prefix accumulator,
// running total, item count and result register.
// ----------------------------------------------------------------------------
module fic_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fic_pkg::VALUE_BITS-1:0]  cfg_wr_data,
  input  logic [fic_pkg::VALUE_BITS-1:0]  in_value,
  input  logic                            in_start_req,
  input  fic_pkg::fic_cmd_t               cmd,
  output fic_pkg::fic_sts_t               sts,
  output logic [fic_pkg::TOTAL_BITS-1:0]  out_inversions,
  output logic                            out_error
);
  import fic_pkg::*;

  logic [COUNT_BITS-1:0]  mem [VALUE_RANGE];
  logic [VALUE_RANGE-1:0] valid_r;

  logic [VALUE_BITS-1:0]  max_value_r;
  logic [TOTAL_BITS-1:0]  total_r;
  logic [TOTAL_BITS-1:0]  total_nxt;
  logic [COUNT_BITS-1:0]  count_r;
  logic [VALUE_BITS-1:0]  val_r;
  logic                   err_r;
  logic                   err_nxt;
  logic [NODE_BITS-1:0]   node_r;
  logic [NODE_BITS-1:0]   node_nxt;
  logic [NODE_BITS-1:0]   low_bit;
  logic [ACC_BITS-1:0]    acc_r;
  logic                   rd_pend_r;
  fic_mode_t              rd_mode_r;
  logic [VALUE_BITS-1:0]  rd_node_r;
  logic [COUNT_BITS-1:0]  rd_data_r;
  logic                   rd_vld_r;
  logic [COUNT_BITS-1:0]  cnt;
  logic                   wr_en;
  logic [SUM_BITS-1:0]    sum;
  logic [TOTAL_BITS-1:0]  out_inv_r;
  logic                   out_err_r;

  // tree word seen by the walk: an entry cleared since start reads as zero
  assign cnt   = rd_vld_r ? rd_data_r : '0;
  assign wr_en = rd_pend_r && (rd_mode_r == MODE_INC);

  // item check at load, count taken as cleared when a run starts
  assign err_nxt = (in_value > max_value_r) ||
                   ((in_value != '0) && !in_start_req && (count_r == COUNT_MAX));

  // lowest set bit steps the walk down (query) or up (update)
  assign low_bit = node_r & (~node_r + NODE_BITS'(1));

  always_comb begin
    node_nxt = node_r;
    if (cmd.load) begin
      node_nxt = {1'b0, max_value_r};
    end else if (cmd.seed_val) begin
      node_nxt = {1'b0, val_r};
    end else if (cmd.rd_issue) begin
      node_nxt = cmd.walk_up ? (node_r + low_bit) : (node_r - low_bit);
    end
  end

  // total plus the greater-than count, one subtract brings it back in range
  always_comb begin
    sum = SUM_BITS'(total_r) + SUM_BITS'(acc_r);
    if (sum >= SUM_BITS'(MODULUS)) begin
      total_nxt = TOTAL_BITS'(sum - SUM_BITS'(MODULUS));
    end else begin
      total_nxt = sum[TOTAL_BITS-1:0];
    end
  end

  // tree memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_node_r] <= cnt + COUNT_BITS'(1);
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[node_r[VALUE_BITS-1:0]];
    end
  end

  // control state: config, total, count, valid bits, read pipeline flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= MAX_VALUE_RST;
      total_r     <= '0;
      count_r     <= '0;
      valid_r     <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_value_r <= cfg_wr_data;
      end
      rd_pend_r <= cmd.rd_issue;
      if (cmd.load && in_start_req) begin
        valid_r <= '0;
        total_r <= '0;
        count_r <= '0;
      end else if (cmd.commit && !err_r) begin
        total_r <= total_nxt;
        if (val_r != '0) begin
          count_r <= count_r + COUNT_BITS'(1);
        end
      end
      if (wr_en) begin
        valid_r[rd_node_r] <= 1'b1;
      end
    end
  end

  // payload registers of the walk
  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    if (cmd.load) begin
      val_r <= in_value;
      err_r <= err_nxt;
    end
    if (cmd.rd_issue) begin
      rd_mode_r <= cmd.mode;
      rd_node_r <= node_r[VALUE_BITS-1:0];
      rd_vld_r  <= valid_r[node_r[VALUE_BITS-1:0]];
    end
    if (cmd.load) begin
      acc_r <= '0;
    end else if (rd_pend_r) begin
      case (rd_mode_r)
        MODE_ADD: acc_r <= acc_r + ACC_BITS'(cnt);
        MODE_SUB: acc_r <= acc_r - ACC_BITS'(cnt);
        default:  acc_r <= acc_r;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_inv_r <= err_r ? total_r : total_nxt;
      out_err_r <= err_r;
    end
  end

  assign out_inversions = out_inv_r;
  assign out_error      = out_err_r;

  assign sts.node_zero = (node_r == '0);
  assign sts.node_oob  = node_r[NODE_BITS-1];
  assign sts.err       = err_r;
  assign sts.val_zero  = (val_r == '0);
  assign sts.rd_pend   = rd_pend_r;

endmodule

// ----- rtl/core/fic_ctrl.sv -----
// ----------------------------------------------------------------------------
// fic_ctrl
// Controller: sequences the two prefix walks and the update walk of one
// word and owns the handshakes.
// ----------------------------------------------------------------------------
module fic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fic_pkg::fic_sts_t sts,
  output fic_pkg::fic_cmd_t cmd
);
  import fic_pkg::*;

  fic_state_t state_r;
  fic_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // state and result flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mode      = MODE_ADD;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_QHI;
        end
      end
      ST_QHI: begin
        if (sts.err) begin
          state_nxt = ST_DONE;
        end else if (sts.node_zero) begin
          cmd.seed_val = 1'b1;
          state_nxt    = ST_QLO;
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.mode     = MODE_ADD;
        end
      end
      ST_QLO: begin
        if (sts.node_zero) begin
          if (sts.val_zero) begin
            state_nxt = ST_TAIL;
          end else begin
            cmd.seed_val = 1'b1;
            state_nxt    = ST_UPD;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.mode     = MODE_SUB;
        end
      end
      ST_UPD: begin
        if (sts.node_zero || sts.node_oob) begin
          state_nxt = ST_TAIL;
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.walk_up  = 1'b1;
          cmd.mode     = MODE_INC;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/fenwick_inversion_counter_unit.sv -----
// ----------------------------------------------------------------------------
// fenwick_inversion_counter_unit
// Streaming inversion counter over a Fenwick tree of per-value counts.
// ----------------------------------------------------------------------------
// One word is worked at a time. The bound walk reads up to 8 nodes. The value
// walk and the update walk together read up to 9 nodes. A zero value skips the
// update walk, and a rejected word skips all walks. The time is set by the
// single tree memory, which is read one node per cycle. The next word is taken
// while the previous result still waits. A finished word then holds in its last
// state until the result slot frees. Reset and start clear the tree at once
// through per-entry valid bits, so there is no clearing pass.
module fenwick_inversion_counter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fic_pkg::VALUE_BITS-1:0]  cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fic_pkg::VALUE_BITS-1:0]  in_value,
  input  logic                            in_start_req,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fic_pkg::TOTAL_BITS-1:0]  out_inversions,
  output logic                            out_error
);
  import fic_pkg::*;

  fic_cmd_t cmd;
  fic_sts_t sts;

  // sequencer
  fic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tree, accumulator and total
  fic_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_value       (in_value),
    .in_start_req   (in_start_req),
    .cmd            (cmd),
    .sts            (sts),
    .out_inversions (out_inversions),
    .out_error      (out_error)
  );

`ifndef SYNTHESIS
  // a taken word keeps the input side closed on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous word still in work");

  // the running total stays reduced
  a_total_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_inversions < MODULUS))
    else $error("inversion total not reduced");

  // no tree read is in flight while the block is idle
  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !sts.rd_pend)
    else $error("tree read pending while idle");
`endif

endmodule
